FILE: design/spq_pkg.sv
// Shared types, codes and command/status structs of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH      = 3'd0,
    ACT_POP_FRONT = 3'd1,
    ACT_POP_BACK  = 3'd2,
    ACT_POP_AT    = 3'd3,
    ACT_FIND      = 3'd4,
    ACT_READ      = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_RANGE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_CNT_M1,
    PTR_INDEX,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic {
    WA_PTR_P1,
    WA_PTR_M1
  } wa_sel_e;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RDATA,
    RES_VALUE
  } res_src_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     in_ready;
    ptr_op_e  ptr_op;
    logic     rd_en;
    logic     wr_en;
    wa_sel_e  wa_sel;
    wd_sel_e  wd_sel;
    cnt_op_e  cnt_op;
    logic     res_set;
    res_src_e res_src;
    status_e  res_status;
    logic     out_load;
  } spq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic    in_valid;
    action_e action;
    logic    count_zero;
    logic    count_full;
    logic    index_ok;
    logic    ptr_zero;
    logic    ptr_last;
    logic    rd_less;
    logic    rd_equal;
    logic    out_busy;
  } spq_stat_t;

endpackage
`default_nettype wire

FILE: design/spq_intf.sv
// Request and response channel interfaces of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
interface spq_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic signed [31:0] value;
  logic [3:0]        index;

  modport source (output valid, output action, output value, output index, input ready);
  modport sink   (input valid, input action, input value, input index, output ready);
endinterface

interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         status;
  logic [4:0]         entry_count;

  modport source (output valid, output result_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input entry_count,
                  output ready);
endinterface
`default_nettype wire

FILE: design/spq_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

FILE: design/spq_datapath.sv
// Datapath: request latch, entry store, pointer, count, result and output register.
`timescale 1ns / 1ps
`default_nettype none
module spq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  spq_req_if.sink                 req_i,
  spq_rsp_if.source               rsp_o,
  input  wire spq_pkg::spq_cmd_t  cmd_i,
  output spq_pkg::spq_stat_t      stat_o
);
  import spq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > INDEX_W) ? CW : INDEX_W;

  logic                      in_fire;
  action_e                   req_action_q;
  logic signed [VALUE_W-1:0] req_value_q;
  logic [INDEX_W-1:0]        req_index_q;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             ptr_q, ptr_d;
  logic [CW-1:0]             wr_ptr;
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] wr_data;
  logic signed [VALUE_W-1:0] res_value_q, res_value_d;
  status_e                   res_status_q;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  status_e                   out_status_q;
  logic [COUNT_W-1:0]        out_count_q;

  assign req_i.ready = cmd_i.in_ready;
  assign in_fire     = req_i.valid & cmd_i.in_ready;

  // Latch the request beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_action_q <= action_e'(req_i.action);
      req_value_q  <= req_i.value;
      req_index_q  <= req_i.index;
    end
  end

  // Pointer next value; the read address follows it
  always_comb begin
    case (cmd_i.ptr_op)
      PTR_HOLD:   ptr_d = ptr_q;
      PTR_ZERO:   ptr_d = '0;
      PTR_CNT_M1: ptr_d = count_q - CW'(1);
      PTR_INDEX:  ptr_d = CW'(IW'(req_index_q));
      PTR_INC:    ptr_d = ptr_q + CW'(1);
      PTR_DEC:    ptr_d = ptr_q - CW'(1);
      default:    ptr_d = ptr_q;
    endcase
  end

  // Entry count next value
  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: count_d = count_q + CW'(1);
      CNT_DEC: count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
  end

  // Select write address and data
  assign wr_ptr  = (cmd_i.wa_sel == WA_PTR_M1) ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));
  assign wr_data = (cmd_i.wd_sel == WD_RDATA) ? rd_data : req_value_q;

  spq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_ptr[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (ptr_d[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Result held until it moves into the output register
  always_comb begin
    case (cmd_i.res_src)
      RES_RDATA: res_value_d = rd_data;
      RES_VALUE: res_value_d = req_value_q;
      default:   res_value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_value_q  <= res_value_d;
      res_status_q <= cmd_i.res_status;
    end
  end

  // Output register: load a result beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.entry_count  = out_count_q;

  // Status toward the controller
  assign stat_o.in_valid   = req_i.valid;
  assign stat_o.action     = req_action_q;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.count_full = (count_q == CW'(DEPTH));
  assign stat_o.index_ok   = (IW'(req_index_q) < IW'(count_q));
  assign stat_o.ptr_zero   = (ptr_q == '0);
  assign stat_o.ptr_last   = ((ptr_q + CW'(1)) == count_q);
  assign stat_o.rd_less    = (rd_data < req_value_q);
  assign stat_o.rd_equal   = (rd_data == req_value_q);
  assign stat_o.out_busy   = out_valid_q & ~rsp_o.ready;

endmodule
`default_nettype wire

FILE: design/spq_ctrl.sv
// Controller state machine: sequences one request over the entry store.
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t       cmd_o
);
  import spq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_CMP,
    S_PUSH_FIN,
    S_POP_FIRST,
    S_POP_SHIFT,
    S_POP_FIN,
    S_FIND_CMP,
    S_READ_WAIT,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.ptr_op     = PTR_HOLD;
    cmd_o.wa_sel     = WA_PTR_P1;
    cmd_o.wd_sel     = WD_VALUE;
    cmd_o.cnt_op     = CNT_HOLD;
    cmd_o.res_src    = RES_ZERO;
    cmd_o.res_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        cmd_o.res_set = 1'b1;
        state_d       = S_RESP;
        case (stat_i.action)
          ACT_PUSH: begin
            if (stat_i.count_full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.ptr_op = PTR_CNT_M1;
              if (stat_i.count_zero) begin
                state_d = S_PUSH_FIN;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_PUSH_CMP;
              end
            end
          end
          ACT_POP_FRONT: begin
            if (stat_i.count_zero) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.ptr_op = PTR_ZERO;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_POP_FIRST;
            end
          end
          ACT_POP_BACK: begin
            if (stat_i.count_zero) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.ptr_op = PTR_CNT_M1;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_POP_FIRST;
            end
          end
          ACT_POP_AT: begin
            if (stat_i.count_zero) begin
              cmd_o.res_status = ST_EMPTY;
            end else if (!stat_i.index_ok) begin
              cmd_o.res_status = ST_RANGE;
            end else begin
              cmd_o.ptr_op = PTR_INDEX;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_POP_FIRST;
            end
          end
          ACT_FIND: begin
            if (stat_i.count_zero) begin
              cmd_o.res_status = ST_MISSING;
            end else begin
              cmd_o.ptr_op = PTR_ZERO;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_FIND_CMP;
            end
          end
          ACT_READ: begin
            if (stat_i.count_zero) begin
              cmd_o.res_status = ST_EMPTY;
            end else if (!stat_i.index_ok) begin
              cmd_o.res_status = ST_RANGE;
            end else begin
              cmd_o.ptr_op = PTR_INDEX;
              cmd_o.rd_en  = 1'b1;
              state_d      = S_READ_WAIT;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      // Shift smaller entries up one place, scanning from the back
      S_PUSH_CMP: begin
        if (stat_i.rd_less) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wa_sel = WA_PTR_P1;
          cmd_o.wd_sel = WD_RDATA;
          cmd_o.ptr_op = PTR_DEC;
          if (stat_i.ptr_zero) begin
            state_d = S_PUSH_FIN;
          end else begin
            cmd_o.rd_en = 1'b1;
          end
        end else begin
          state_d = S_PUSH_FIN;
        end
      end

      // Drop the new value into the gap
      S_PUSH_FIN: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = WA_PTR_P1;
        cmd_o.wd_sel = WD_VALUE;
        cmd_o.cnt_op = CNT_INC;
        state_d      = S_RESP;
      end

      // Capture the removed entry, then close the gap
      S_POP_FIRST: begin
        cmd_o.res_set = 1'b1;
        cmd_o.res_src = RES_RDATA;
        if (stat_i.ptr_last) begin
          state_d = S_POP_FIN;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          cmd_o.rd_en  = 1'b1;
          state_d      = S_POP_SHIFT;
        end
      end

      S_POP_SHIFT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wa_sel = WA_PTR_M1;
        cmd_o.wd_sel = WD_RDATA;
        if (stat_i.ptr_last) begin
          state_d = S_POP_FIN;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          cmd_o.rd_en  = 1'b1;
        end
      end

      S_POP_FIN: begin
        cmd_o.cnt_op = CNT_DEC;
        state_d      = S_RESP;
      end

      // Scan from the front until a match or the last entry
      S_FIND_CMP: begin
        if (stat_i.rd_equal) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_src = RES_VALUE;
          state_d       = S_RESP;
        end else if (stat_i.ptr_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_MISSING;
          state_d          = S_RESP;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          cmd_o.rd_en  = 1'b1;
        end
      end

      S_READ_WAIT: begin
        cmd_o.res_set = 1'b1;
        cmd_o.res_src = RES_RDATA;
        state_d       = S_RESP;
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/sorted_priority_queue.sv
// Sorted priority queue: top level joining controller and datapath.
//
// Usage: requests arrive on req_i (action, value, index) and each request
// gives exactly one response beat on rsp_o (result_value, status,
// entry_count). Both channels move a beat when valid and ready are high at
// a rising clock edge. Up to DEPTH signed values are kept in descending
// order in a RAM with one write and one registered read port.
// One request is worked at a time: no-op and rejected requests go
// straight to the response, a read fetches its entry first, and find,
// pops and pushes scan or shift the entries one entry per cycle through
// the RAM port. The next request beat is taken only once the result is
// loaded into the output register.
// The next request is taken while a response still waits in the output
// register; a stalled receiver holds that beat and the block waits with
// its next result until the register frees.
// Reset clears the entry count and the control state; the RAM needs no
// clearing pass, since only positions below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule
`default_nettype wire
